### sv/capm_pkg.sv
`default_nettype none
package capm_pkg;

  localparam int OUTER_DIVIDE_DEF = 2;

  localparam int GAIN_W = 16;
  localparam int LIM_W  = 15;
  localparam int OPND_W = 34;
  localparam int ACC_W  = 56;
  localparam int INN_W  = ACC_W - 8;
  localparam int MIX_W  = 52;
  localparam int DUTY_W = 11;
  localparam int CIDX_W = 4;

  localparam int THR_ON     = 1050;
  localparam int THR_BASE   = 1000;
  localparam int YAW_LIM    = 25600;
  localparam int DUTY_MAX   = 2047;
  localparam int DIV5_RECIP = 52429;

  localparam logic [CIDX_W-1:0] REG_OUTER_KP  = 4'd0;
  localparam logic [CIDX_W-1:0] REG_OUTER_KI  = 4'd1;
  localparam logic [CIDX_W-1:0] REG_OUTER_KD  = 4'd2;
  localparam logic [CIDX_W-1:0] REG_INNER_KP  = 4'd3;
  localparam logic [CIDX_W-1:0] REG_INNER_KI  = 4'd4;
  localparam logic [CIDX_W-1:0] REG_INNER_KD  = 4'd5;
  localparam logic [CIDX_W-1:0] REG_INT_LIMIT = 4'd6;
  localparam logic [CIDX_W-1:0] REG_MIX_MODE  = 4'd7;

  typedef struct packed {
    logic en;
    logic clr;
  } mac_ctl_t;

  function automatic logic signed [17:0] div5_trunc(input logic signed [17:0] v);
    logic [17:0] mag;
    logic [33:0] prod;
    logic signed [17:0] q;
    mag  = v[17] ? 18'(-v) : 18'(v);
    prod = 34'(mag) * 34'(DIV5_RECIP);
    q    = signed'({2'b00, prod[33:18]});
    return v[17] ? -q : q;
  endfunction

  function automatic logic signed [15:0] clamp_int(input logic signed [OPND_W:0] v,
                                                   input logic [LIM_W-1:0] lim);
    logic signed [OPND_W:0] hi;
    hi = (OPND_W+1)'(signed'({1'b0, lim}));
    if (v > hi) return 16'(hi);
    if (v < -hi) return 16'(-hi);
    return 16'(v);
  endfunction

  function automatic logic [DUTY_W-1:0] to_duty(input logic signed [MIX_W-1:0] q);
    logic signed [MIX_W-9:0] d;
    d = q[MIX_W-1:8];
    if (q <= 0) return '0;
    if (d > (MIX_W-8)'(DUTY_MAX)) return DUTY_W'(DUTY_MAX);
    return d[DUTY_W-1:0];
  endfunction

endpackage
`default_nettype wire

### sv/capm_mac.sv
`default_nettype none
module capm_mac (
  input  wire logic                                 clk,
  input  wire capm_pkg::mac_ctl_t                   ctl,
  input  wire logic [capm_pkg::GAIN_W-1:0]          gain,
  input  wire logic signed [capm_pkg::OPND_W-1:0]   opnd,
  output logic signed [capm_pkg::ACC_W-1:0]         acc
);

  logic signed [capm_pkg::OPND_W+capm_pkg::GAIN_W:0] prod;
  logic signed [capm_pkg::ACC_W-1:0] acc_r;
  logic signed [capm_pkg::ACC_W-1:0] acc_nxt;

  assign prod = signed'({1'b0, gain}) * opnd;

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.en) begin
      acc_nxt = (ctl.clr ? '0 : acc_r) + capm_pkg::ACC_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule
`default_nettype wire

### sv/cascaded_attitude_pid_mixer_unit.sv
// Cascaded attitude PID controller with X-quad motor mixer.
// Input channel (in_valid/in_stall): one control tick of attitude, stick,
// gyro, throttle, armed and height fields. Result channel (out_valid/
// out_stall): four motor duties, 0..2047, one item per tick.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data): gains, integral
// limit and mix mode; cfg_ready is always high, write only while idle.
// All products go through one shared multiply-accumulate unit, one product
// per cycle, under a step sequencer. A tick that runs the outer loop steps
// through prepare, 16 multiply steps (outer, then inner) and mix; other
// ticks run prepare, 8 inner multiply steps and mix. in_stall stays high
// from accept until the result is loaded, so a new tick is taken only
// after the previous one is through.
// If out_stall holds a previous result, the final mixing step waits.
// Synchronous reset clears gains to defaults, all integrators, previous
// errors and rates, held outer outputs and the tick divider.
`default_nettype none
module cascaded_attitude_pid_mixer_unit #(
  parameter int OUTER_DIVIDE = capm_pkg::OUTER_DIVIDE_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [15:0]                in_roll_angle,
  input  wire logic signed [15:0]                in_pitch_angle,
  input  wire logic signed [9:0]                 in_stick_roll,
  input  wire logic signed [9:0]                 in_stick_pitch,
  input  wire logic signed [9:0]                 in_stick_yaw,
  input  wire logic signed [15:0]                in_rate_x,
  input  wire logic signed [15:0]                in_rate_y,
  input  wire logic signed [15:0]                in_rate_z,
  input  wire logic signed [15:0]                in_raw_rate_z,
  input  wire logic [10:0]                       in_throttle,
  input  wire logic                              in_armed,
  input  wire logic signed [11:0]                in_height_correction,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [10:0]                            out_motor_front_right,
  output logic [10:0]                            out_motor_front_left,
  output logic [10:0]                            out_motor_rear_left,
  output logic [10:0]                            out_motor_rear_right,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [capm_pkg::CIDX_W-1:0]       cfg_index,
  input  wire logic [15:0]                       cfg_data
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_PREP = 5'd1;
  localparam logic [4:0] S_ORP  = 5'd2;
  localparam logic [4:0] S_ORI  = 5'd3;
  localparam logic [4:0] S_ORD  = 5'd4;
  localparam logic [4:0] S_OPP  = 5'd5;
  localparam logic [4:0] S_OPI  = 5'd6;
  localparam logic [4:0] S_OPD  = 5'd7;
  localparam logic [4:0] S_OYP  = 5'd8;
  localparam logic [4:0] S_OYD  = 5'd9;
  localparam logic [4:0] S_IRP  = 5'd10;
  localparam logic [4:0] S_IRI  = 5'd11;
  localparam logic [4:0] S_IRD  = 5'd12;
  localparam logic [4:0] S_IPP  = 5'd13;
  localparam logic [4:0] S_IPI  = 5'd14;
  localparam logic [4:0] S_IPD  = 5'd15;
  localparam logic [4:0] S_IYP  = 5'd16;
  localparam logic [4:0] S_IYD  = 5'd17;
  localparam logic [4:0] S_MIX  = 5'd18;

  localparam int OW = capm_pkg::OPND_W;
  localparam int MW = capm_pkg::MIX_W;
  localparam int IW = capm_pkg::INN_W;

  logic [4:0] state_r;

  logic [15:0] okp_r, oki_r, okd_r, ikp_r, iki_r, ikd_r;
  logic [capm_pkg::LIM_W-1:0] lim_r;
  logic mix_r;

  logic signed [15:0] roll_r, pitch_r, rx_r, ry_r, rz_r, rawz_r;
  logic signed [9:0]  sroll_r, spitch_r, syaw_r;
  logic [10:0]        thr_r;
  logic               armed_r;
  logic signed [11:0] hc_r;

  logic signed [16:0] e0_r, e1_r, cy_r;
  logic               orun_r;
  logic signed [15:0] oi_r [2];
  logic signed [15:0] ii_r [2];
  logic signed [16:0] pe_r [2];
  logic signed [15:0] pr_r [3];
  logic signed [31:0] oo_r [3];
  logic [1:0]         td_r;
  logic signed [IW-1:0] inr_r, inp_r;

  logic [10:0] m_fr_r, m_fl_r, m_rl_r, m_rr_r;
  logic        out_valid_r;

  capm_pkg::mac_ctl_t mac_ctl;
  logic [15:0]                      mac_gain;
  logic signed [OW-1:0]             mac_opnd;
  logic signed [capm_pkg::ACC_W-1:0] acc;
  logic signed [IW-1:0]             acc_sh;

  logic signed [17:0] d0, d1, dy;
  logic signed [OW-1:0] x0, x1, xy;
  logic               accept;
  logic               mix_go;
  logic signed [IW-1:0] yaw_lim;
  logic signed [15:0] yaw_c;
  logic signed [13:0] base_s;
  logic signed [MW-1:0] base, yv, rv, pv;
  logic               thr_low;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign mix_go    = (state_r == S_MIX) && !(out_valid_r && out_stall);
  assign acc_sh    = acc[capm_pkg::ACC_W-1:8];

  assign d0 = capm_pkg::div5_trunc(18'(signed'({sroll_r, 6'b0})));
  assign d1 = capm_pkg::div5_trunc(18'(signed'({spitch_r, 6'b0})));
  assign dy = capm_pkg::div5_trunc(signed'({syaw_r, 8'b0}));

  assign x0 = OW'(oo_r[0]) + OW'(rx_r);
  assign x1 = OW'(oo_r[1]) + OW'(ry_r);
  assign xy = OW'(oo_r[2]) + OW'(rz_r);

  always_comb begin
    mac_ctl  = '{en: 1'b1, clr: 1'b0};
    mac_gain = '0;
    mac_opnd = '0;
    case (state_r)
      S_ORP: begin mac_ctl.clr = 1'b1; mac_gain = okp_r; mac_opnd = OW'(e0_r); end
      S_ORI: begin mac_gain = oki_r; mac_opnd = OW'(oi_r[0]); end
      S_ORD: begin mac_gain = okd_r; mac_opnd = OW'(e0_r) - OW'(pe_r[0]); end
      S_OPP: begin mac_ctl.clr = 1'b1; mac_gain = okp_r; mac_opnd = OW'(e1_r); end
      S_OPI: begin mac_gain = oki_r; mac_opnd = OW'(oi_r[1]); end
      S_OPD: begin mac_gain = okd_r; mac_opnd = OW'(e1_r) - OW'(pe_r[1]); end
      S_OYP: begin mac_ctl.clr = 1'b1; mac_gain = okp_r; mac_opnd = OW'(cy_r); end
      S_OYD: begin mac_gain = okd_r; mac_opnd = OW'(rawz_r); end
      S_IRP: begin mac_ctl.clr = 1'b1; mac_gain = ikp_r; mac_opnd = x0; end
      S_IRI: begin mac_gain = iki_r; mac_opnd = OW'(ii_r[0]); end
      S_IRD: begin mac_gain = ikd_r; mac_opnd = OW'(rx_r) - OW'(pr_r[0]); end
      S_IPP: begin mac_ctl.clr = 1'b1; mac_gain = ikp_r; mac_opnd = x1; end
      S_IPI: begin mac_gain = iki_r; mac_opnd = OW'(ii_r[1]); end
      S_IPD: begin mac_gain = ikd_r; mac_opnd = OW'(ry_r) - OW'(pr_r[1]); end
      S_IYP: begin mac_ctl.clr = 1'b1; mac_gain = ikp_r; mac_opnd = xy; end
      S_IYD: begin mac_gain = ikd_r; mac_opnd = OW'(rz_r) - OW'(pr_r[2]); end
      default: mac_ctl.en = 1'b0;
    endcase
  end

  capm_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .gain (mac_gain),
    .opnd (mac_opnd),
    .acc  (acc)
  );

  always_comb begin
    yaw_lim = acc_sh;
    if (acc_sh > IW'(capm_pkg::YAW_LIM)) yaw_lim = IW'(capm_pkg::YAW_LIM);
    else if (acc_sh < -IW'(capm_pkg::YAW_LIM)) yaw_lim = -IW'(capm_pkg::YAW_LIM);
    yaw_c   = 16'(yaw_lim);
    base_s  = 14'(signed'({2'b00, thr_r})) - 14'(capm_pkg::THR_BASE);
    if (mix_r) base_s = base_s + 14'(hc_r);
    base    = MW'(base_s) <<< 8;
    yv      = MW'(yaw_c);
    rv      = MW'(inr_r);
    pv      = MW'(inp_r);
    thr_low = (thr_r <= 11'(capm_pkg::THR_ON));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      okp_r <= 16'd2560;
      oki_r <= '0;
      okd_r <= '0;
      ikp_r <= 16'd2560;
      iki_r <= '0;
      ikd_r <= '0;
      lim_r <= 15'd25600;
      mix_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        capm_pkg::REG_OUTER_KP:  okp_r <= cfg_data;
        capm_pkg::REG_OUTER_KI:  oki_r <= cfg_data;
        capm_pkg::REG_OUTER_KD:  okd_r <= cfg_data;
        capm_pkg::REG_INNER_KP:  ikp_r <= cfg_data;
        capm_pkg::REG_INNER_KI:  iki_r <= cfg_data;
        capm_pkg::REG_INNER_KD:  ikd_r <= cfg_data;
        capm_pkg::REG_INT_LIMIT: lim_r <= cfg_data[capm_pkg::LIM_W-1:0];
        capm_pkg::REG_MIX_MODE:  mix_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      roll_r   <= in_roll_angle;
      pitch_r  <= in_pitch_angle;
      sroll_r  <= in_stick_roll;
      spitch_r <= in_stick_pitch;
      syaw_r   <= in_stick_yaw;
      rx_r     <= in_rate_x;
      ry_r     <= in_rate_y;
      rz_r     <= in_rate_z;
      rawz_r   <= in_raw_rate_z;
      thr_r    <= in_throttle;
      armed_r  <= in_armed;
      hc_r     <= in_height_correction;
    end
    if (state_r == S_PREP) begin
      e0_r <= 17'(roll_r) + 17'(d0);
      e1_r <= 17'(pitch_r) + 17'(d1);
      cy_r <= 17'(dy);
    end
    if (state_r == S_IPP) inr_r <= acc_sh;
    if (state_r == S_IYP) inp_r <= acc_sh;
    if (mix_go) begin
      if (thr_low || !armed_r) begin
        m_fr_r <= '0;
        m_fl_r <= '0;
        m_rl_r <= '0;
        m_rr_r <= '0;
      end else begin
        m_fr_r <= capm_pkg::to_duty(base + yv - rv - pv);
        m_fl_r <= capm_pkg::to_duty(base - yv + rv - pv);
        m_rl_r <= capm_pkg::to_duty(base + yv + rv + pv);
        m_rr_r <= capm_pkg::to_duty(base - yv - rv + pv);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      orun_r      <= 1'b0;
      td_r        <= '0;
      oi_r        <= '{default: '0};
      ii_r        <= '{default: '0};
      pe_r        <= '{default: '0};
      pr_r        <= '{default: '0};
      oo_r        <= '{default: '0};
    end else begin
      if (out_valid_r && !out_stall && !mix_go) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) state_r <= S_PREP;
        end
        S_PREP: begin
          if (td_r >= 2'(OUTER_DIVIDE)) begin
            orun_r  <= 1'b1;
            td_r    <= 2'd1;
            state_r <= S_ORP;
          end else begin
            orun_r  <= 1'b0;
            if (td_r < 2'd3) td_r <= td_r + 2'd1;
            state_r <= S_IRP;
          end
        end
        S_ORP: begin
          oi_r[0] <= capm_pkg::clamp_int((OW+1)'(oi_r[0]) + (OW+1)'(e0_r), lim_r);
          state_r <= S_ORI;
        end
        S_OPP: begin
          oo_r[0] <= 32'(acc_sh);
          pe_r[0] <= e0_r;
          oi_r[1] <= capm_pkg::clamp_int((OW+1)'(oi_r[1]) + (OW+1)'(e1_r), lim_r);
          state_r <= S_OPI;
        end
        S_OYP: begin
          oo_r[1] <= 32'(acc_sh);
          pe_r[1] <= e1_r;
          state_r <= S_OYD;
        end
        S_IRP: begin
          if (orun_r) oo_r[2] <= 32'(acc_sh);
          ii_r[0] <= capm_pkg::clamp_int((OW+1)'(ii_r[0]) + (OW+1)'(x0), lim_r);
          state_r <= S_IRI;
        end
        S_IPP: begin
          ii_r[1] <= capm_pkg::clamp_int((OW+1)'(ii_r[1]) + (OW+1)'(x1), lim_r);
          state_r <= S_IPI;
        end
        S_MIX: begin
          if (mix_go) begin
            pr_r[0]     <= rx_r;
            pr_r[1]     <= ry_r;
            pr_r[2]     <= rz_r;
            if (thr_low) begin
              oi_r <= '{default: '0};
              ii_r <= '{default: '0};
            end
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= state_r + 5'd1;
      endcase
    end
  end

  assign out_valid             = out_valid_r;
  assign out_motor_front_right = m_fr_r;
  assign out_motor_front_left  = m_fl_r;
  assign out_motor_rear_left   = m_rl_r;
  assign out_motor_rear_right  = m_rr_r;

endmodule
`default_nettype wire

### tb/cascaded_attitude_pid_mixer_unit_test.sv
`timescale 1ns / 100ps
module cascaded_attitude_pid_mixer_unit_test;

  typedef struct {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [9:0]  stick_roll;
    logic signed [9:0]  stick_pitch;
    logic signed [9:0]  stick_yaw;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic signed [15:0] raw_rate_z;
    logic [10:0]        throttle;
    logic               armed;
    logic signed [11:0] height;
  } tick_t;

  typedef struct packed {
    logic [10:0] fr;
    logic [10:0] fl;
    logic [10:0] rl;
    logic [10:0] rr;
  } duty_t;

  class MotorScoreboard;
    longint okp, oki, okd, ikp, iki, ikd, ilim;
    bit mode;
    longint outer_acc[2], inner_acc[2], prev_err[2], prev_rate[3], outer_cmd[3];
    int divider;
    duty_t duties_due[$];
    int mismatches;

    function new();
      okp = 2560; oki = 0; okd = 0;
      ikp = 2560; iki = 0; ikd = 0;
      ilim = 25600; mode = 0;
      foreach (outer_acc[i]) begin
        outer_acc[i] = 0; inner_acc[i] = 0; prev_err[i] = 0;
      end
      foreach (prev_rate[i]) begin
        prev_rate[i] = 0; outer_cmd[i] = 0;
      end
      divider = 0;
      mismatches = 0;
    endfunction

    function void configure(logic [capm_pkg::CIDX_W-1:0] idx, logic [15:0] data);
      case (idx)
        capm_pkg::REG_OUTER_KP:  okp = data;
        capm_pkg::REG_OUTER_KI:  oki = data;
        capm_pkg::REG_OUTER_KD:  okd = data;
        capm_pkg::REG_INNER_KP:  ikp = data;
        capm_pkg::REG_INNER_KI:  iki = data;
        capm_pkg::REG_INNER_KD:  ikd = data;
        capm_pkg::REG_INT_LIMIT: ilim = data[14:0];
        capm_pkg::REG_MIX_MODE:  mode = data[0];
        default: ;
      endcase
    endfunction

    function longint clampl(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function logic [10:0] duty(longint q);
      longint d;
      if (q <= 0) return 0;
      d = q >>> 8;
      if (d > capm_pkg::DUTY_MAX) d = capm_pkg::DUTY_MAX;
      return d[10:0];
    endfunction

    function void note(tick_t t);
      longint ang[2], stk[2], rt[3], e, c, x, r, p, y, base;
      duty_t d;
      ang[0] = t.roll_angle; ang[1] = t.pitch_angle;
      stk[0] = t.stick_roll; stk[1] = t.stick_pitch;
      rt[0] = t.rate_x; rt[1] = t.rate_y; rt[2] = t.rate_z;
      if (divider >= capm_pkg::OUTER_DIVIDE_DEF) begin
        for (int a = 0; a < 2; a++) begin
          e = ang[a] + (stk[a] * 64) / 5;
          outer_acc[a] = clampl(outer_acc[a] + e, ilim);
          outer_cmd[a] = (okp * e + oki * outer_acc[a] + okd * (e - prev_err[a])) >>> 8;
          prev_err[a] = e;
        end
        c = (longint'(t.stick_yaw) * 256) / 5;
        outer_cmd[2] = (okp * c + okd * longint'(t.raw_rate_z)) >>> 8;
        divider = 1;
      end else if (divider < 3) begin
        divider++;
      end
      x = outer_cmd[0] + rt[0];
      inner_acc[0] = clampl(inner_acc[0] + x, ilim);
      r = (ikp * x + iki * inner_acc[0] + ikd * (rt[0] - prev_rate[0])) >>> 8;
      x = outer_cmd[1] + rt[1];
      inner_acc[1] = clampl(inner_acc[1] + x, ilim);
      p = (ikp * x + iki * inner_acc[1] + ikd * (rt[1] - prev_rate[1])) >>> 8;
      y = clampl((ikp * (outer_cmd[2] + rt[2]) + ikd * (rt[2] - prev_rate[2])) >>> 8,
                 capm_pkg::YAW_LIM);
      foreach (prev_rate[i]) prev_rate[i] = rt[i];
      d = '0;
      if (t.throttle > capm_pkg::THR_ON) begin
        base = (longint'(t.throttle) - capm_pkg::THR_BASE) * 256;
        if (mode) base += longint'(t.height) * 256;
        d.fr = duty(base + y - r - p);
        d.fl = duty(base - y + r - p);
        d.rl = duty(base + y + r + p);
        d.rr = duty(base - y - r + p);
      end else begin
        outer_acc[0] = 0; outer_acc[1] = 0;
        inner_acc[0] = 0; inner_acc[1] = 0;
      end
      if (!t.armed) d = '0;
      duties_due.push_back(d);
    endfunction

    function void check(duty_t got);
      duty_t want;
      if (duties_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d %0d %0d %0d",
                                       got.fr, got.fl, got.rl, got.rr);
        return;
      end
      want = duties_due.pop_front();
      if (got != want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("duty mismatch: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                   want.fr, want.fl, want.rl, want.rr, got.fr, got.fl, got.rl, got.rr);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [15:0] in_roll_angle = 0, in_pitch_angle = 0;
  logic signed [9:0] in_stick_roll = 0, in_stick_pitch = 0, in_stick_yaw = 0;
  logic signed [15:0] in_rate_x = 0, in_rate_y = 0, in_rate_z = 0, in_raw_rate_z = 0;
  logic [10:0] in_throttle = 0;
  logic in_armed = 0;
  logic signed [11:0] in_height_correction = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [10:0] out_motor_front_right, out_motor_front_left;
  logic [10:0] out_motor_rear_left, out_motor_rear_right;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [capm_pkg::CIDX_W-1:0] cfg_index = 0;
  logic [15:0] cfg_data = 0;

  MotorScoreboard motors = new();
  bit drain_quiet = 0;

  cascaded_attitude_pid_mixer_unit dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      motors.note('{in_roll_angle, in_pitch_angle, in_stick_roll, in_stick_pitch,
                    in_stick_yaw, in_rate_x, in_rate_y, in_rate_z, in_raw_rate_z,
                    in_throttle, in_armed, in_height_correction});
    if (rst_n && out_valid && !out_stall)
      motors.check('{out_motor_front_right, out_motor_front_left,
                     out_motor_rear_left, out_motor_rear_right});
  end

  initial begin
    int n;
    forever begin
      if (drain_quiet || $urandom_range(0, 9) < 6) begin
        n = $urandom_range(1, 20);
        out_stall <= 0;
      end else begin
        n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 60);
        out_stall <= 1;
      end
      repeat (n) @(posedge clk);
    end
  end

  task automatic send_tick(tick_t t, int gap);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_roll_angle <= t.roll_angle;
    in_pitch_angle <= t.pitch_angle;
    in_stick_roll <= t.stick_roll;
    in_stick_pitch <= t.stick_pitch;
    in_stick_yaw <= t.stick_yaw;
    in_rate_x <= t.rate_x;
    in_rate_y <= t.rate_y;
    in_rate_z <= t.rate_z;
    in_raw_rate_z <= t.raw_rate_z;
    in_throttle <= t.throttle;
    in_armed <= t.armed;
    in_height_correction <= t.height;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(logic [capm_pkg::CIDX_W-1:0] idx, logic [15:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    motors.configure(idx, data);
  endtask

  task automatic drain();
    in_valid <= 0;
    drain_quiet = ($urandom_range(0, 1) == 1);
    while (motors.duties_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    drain_quiet = 0;
  endtask

  task automatic write_gains(logic [15:0] g[6], logic [15:0] lim, bit mode);
    drain();
    for (int i = 0; i < 6; i++) write_reg(capm_pkg::CIDX_W'(i), g[i]);
    write_reg(capm_pkg::REG_INT_LIMIT, lim);
    write_reg(capm_pkg::REG_MIX_MODE, 16'(mode));
    write_reg(capm_pkg::CIDX_W'($urandom_range(8, 15)), 16'($urandom));
    cfg_valid <= 0;
  endtask

  function automatic tick_t rand_tick(bit wild);
    tick_t t;
    int k;
    if (wild) begin
      t = '{16'($urandom), 16'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
            16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
            11'($urandom), 1'($urandom), 12'($urandom)};
      return t;
    end
    t.roll_angle = 16'($urandom_range(0, 8191) - 4096);
    t.pitch_angle = 16'($urandom_range(0, 8191) - 4096);
    t.stick_roll = 10'($urandom);
    t.stick_pitch = 10'($urandom);
    t.stick_yaw = 10'($urandom);
    t.rate_x = 16'($urandom_range(0, 4095) - 2048);
    t.rate_y = 16'($urandom_range(0, 4095) - 2048);
    t.rate_z = 16'($urandom_range(0, 4095) - 2048);
    t.raw_rate_z = 16'($urandom_range(0, 4095) - 2048);
    k = $urandom_range(0, 9);
    t.throttle = (k < 8) ? 11'($urandom_range(1060, 1900)) : 11'($urandom_range(0, 1050));
    t.armed = ($urandom_range(0, 9) != 0);
    t.height = 12'($urandom_range(0, 399) - 200);
    return t;
  endfunction

  function automatic int rand_gap();
    int k;
    k = $urandom_range(0, 19);
    if (k < 12) return 0;
    if (k < 18) return $urandom_range(1, 4);
    return $urandom_range(10, 50);
  endfunction

  task automatic random_run(int count, bit calm);
    for (int i = 0; i < count; i++) begin
      send_tick(rand_tick($urandom_range(0, 9) == 0), calm ? 0 : rand_gap());
      if (i == count / 2 && !calm) drain();
    end
  endtask

  initial begin
    logic [15:0] g[6];
    tick_t t;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    t = '{16'sh7FFF, 16'sh7FFF, 10'sh1FF, 10'sh1FF, 10'sh1FF, 16'sh7FFF, 16'sh7FFF,
          16'sh7FFF, 16'sh7FFF, 11'd2047, 1'b1, 12'sh7FF};
    send_tick(t, 0);
    t = '{16'sh8000, 16'sh8000, 10'sh200, 10'sh200, 10'sh200, 16'sh8000, 16'sh8000,
          16'sh8000, 16'sh8000, 11'd2047, 1'b1, 12'sh800};
    send_tick(t, 0);
    for (int i = 0; i < 6; i++) begin
      t = rand_tick(0);
      t.throttle = (i == 0) ? 11'd0 : (i == 1) ? 11'd1050 : (i == 2) ? 11'd1051
                 : (i == 3) ? 11'd2047 : 11'd1500;
      t.armed = (i != 4);
      send_tick(t, i % 2);
    end
    t = '{0, 0, 10'sh1FF, 0, 10'sh1FF, 0, 0, 16'sh7FFF, 16'sh7FFF, 11'd1500, 1, 0};
    send_tick(t, 0);
    send_tick(t, 0);
    t = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 11'd1500, 1, 0};
    send_tick(t, 3);
    send_tick(t, 0);

    g = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
    write_gains(g, 16'd0, 1);
    for (int i = 0; i < 4; i++) send_tick(rand_tick(i[0]), 0);
    g = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    write_gains(g, 16'h7FFF, 1);
    for (int i = 0; i < 6; i++) send_tick(rand_tick(i[0]), 0);
    g = '{16'd2560, 16'd64, 16'd128, 16'd2560, 16'd32, 16'd64};
    write_gains(g, 16'd25600, 0);
    random_run(150, 0);
    for (int ph = 0; ph < 3; ph++) begin
      for (int i = 0; i < 6; i++) g[i] = 16'($urandom_range(0, 1200));
      write_gains(g, 16'($urandom_range(0, 32767)), 1'($urandom));
      random_run(130, ph == 1);
    end
    g = '{16'd256, 16'd16, 16'd32, 16'd512, 16'd8, 16'd16};
    write_gains(g, 16'd2000, 1);
    random_run(60, 0);

    in_valid <= 0;
    while (motors.duties_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (motors.mismatches == 0)
      $display("cascaded_attitude_pid_mixer_unit_test: PASS");
    else
      $display("cascaded_attitude_pid_mixer_unit_test: FAIL");
    $finish;
  end

  initial begin
    #5ms;
    $display("cascaded_attitude_pid_mixer_unit_test: FAIL");
    $finish;
  end
endmodule
